// ===== sv/cytosine_context_counter_top_assert.svh =====
// Assertion macros for the cytosine context counter.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message. In synthesis they expand to nothing.
`ifndef CYTOSINE_CONTEXT_COUNTER_TOP_ASSERT_SVH
`define CYTOSINE_CONTEXT_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CCC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CCC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg)
`define CCC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg)
`endif
`endif

// ===== sv/ccc_pkg.sv =====
package ccc_pkg;

	// Nucleotide codes.
	typedef logic [2:0] base_t;
	localparam base_t BASE_C     = 3'd0;
	localparam base_t BASE_G     = 3'd1;
	localparam base_t BASE_OTHER = 3'd4;

	// Counter geometry.
	localparam int CCC_COUNT_WIDTH = 32;
	localparam int OUT_WIDTH       = 32;
	localparam int N_CTX           = 4;
	localparam int N_COUNTERS      = 2 * N_CTX;

	// Context rule number, 0 meaning no contribution.
	typedef logic [3:0] rule_t;
	localparam rule_t RULE_NONE = 4'd0;

	// Half-count additions, element order next_c, prev_c, next_t, prev_t.
	typedef logic [N_CTX-1:0][1:0] add_vec_t;

	// Rule for a C centre, indexed [previous][next].
	localparam rule_t C_RULE [0:4][0:4] = '{
		'{4'd4, 4'd3, 4'd3, 4'd5, 4'd3},
		'{4'd1, 4'd0, 4'd0, 4'd2, 4'd0},
		'{4'd1, 4'd0, 4'd0, 4'd2, 4'd0},
		'{4'd7, 4'd6, 4'd6, 4'd8, 4'd6},
		'{4'd1, 4'd0, 4'd0, 4'd2, 4'd0}
	};

	// Rule for a G centre, indexed [next][previous].
	localparam rule_t G_RULE [0:4][0:4] = '{
		'{4'd0, 4'd3, 4'd6, 4'd0, 4'd0},
		'{4'd1, 4'd4, 4'd7, 4'd1, 4'd1},
		'{4'd2, 4'd5, 4'd8, 4'd2, 4'd2},
		'{4'd0, 4'd3, 4'd6, 4'd0, 4'd0},
		'{4'd0, 4'd3, 4'd6, 4'd0, 4'd0}
	};

	// Additions per rule, written as {prev_t, next_t, prev_c, next_c}.
	localparam add_vec_t RULE_ADD [0:8] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd2},
		'{2'd0, 2'd2, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd2, 2'd0},
		'{2'd0, 2'd0, 2'd1, 2'd1},
		'{2'd0, 2'd1, 2'd1, 2'd0},
		'{2'd2, 2'd0, 2'd0, 2'd0},
		'{2'd1, 2'd0, 2'd0, 2'd1},
		'{2'd1, 2'd1, 2'd0, 2'd0}
	};

	// One three-base window to be evaluated.
	typedef struct packed {
		base_t prev;
		base_t centre;
		base_t next;
		logic  zone;
		logic  second_zone;
		logic  enable;
	} ccc_win_t;

	// Increments for the in-zone and out-of-zone counter sets.
	typedef struct packed {
		add_vec_t out_add;
		add_vec_t in_add;
	} ccc_inc_t;

endpackage

// ===== sv/ccc_eval.sv =====
// Evaluates one centre base against its neighbours and returns the
// half-count increments for the selected counter set.
module ccc_eval import ccc_pkg::*; (
	input  ccc_win_t win,
	output ccc_inc_t inc
);

	rule_t    rule;
	add_vec_t add;

	// Context rule from the centre type.
	always_comb begin
		case (win.centre)
			BASE_C:  rule = C_RULE[win.prev][win.next];
			BASE_G:  rule = G_RULE[win.next][win.prev];
			default: rule = RULE_NONE;
		endcase
	end

	assign add = RULE_ADD[rule];

	// In-zone set when the zone flag is set, else the out set unless the
	// position lies in the second zone.
	always_comb begin
		inc = '0;
		if (win.enable) begin
			if (win.zone) begin
				inc.in_add = add;
			end else if (!win.second_zone) begin
				inc.out_add = add;
			end
		end
	end

endmodule

// ===== sv/cytosine_context_counter_top.sv =====
// Cytosine context counter.
// Input stream s_*: one base per request. s_tdata[2:0] is the base code
// (C, G, A, T, other; codes above other count as other), s_tdata[3] the
// main zone flag, s_tdata[4] the second zone flag; s_tlast marks the final
// base of a sequence. Output stream m_*: one request per sequence carrying
// the eight half-count totals, each 32 bits and capped at all ones.
// Throughput is one base per cycle while no final base waits in the input stage.
// A base is registered in the input stage and folded into the counters when it
// leaves that stage; the final base also loads the totals into the result register and raises m_tvalid.
// The final base evaluates both the pending centre and itself, then clears
// the counters and the window so the next sequence starts fresh.
// While the receiver holds off, bases keep flowing; only a final base
// waits in the input stage until the previous result has been taken.
// Reset clears the counters, the window and both valid flags at once.
`include "cytosine_context_counter_top_assert.svh"

module cytosine_context_counter_top import ccc_pkg::*; #(
	parameter int COUNT_WIDTH = CCC_COUNT_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [2:0] base, [3] zone_flag, [4] second_zone_flag, [7:5] zero
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] in_next_c, [63:32] in_prev_c, [95:64] in_next_t,
	// [127:96] in_prev_t, [159:128] out_next_c, [191:160] out_prev_c,
	// [223:192] out_next_t, [255:224] out_prev_t
	output logic [255:0] m_tdata
);

	// Input stage
	logic  valid_s1;
	base_t base_s1;
	logic  zone_s1;
	logic  zone2_s1;
	logic  last_s1;

	// Window
	base_t prev_q;
	base_t centre_q;
	logic  zone_q;
	logic  zone2_q;

	// Counters and result
	logic [COUNT_WIDTH-1:0] cnt_q [N_COUNTERS];
	logic [OUT_WIDTH-1:0]   res_q [N_COUNTERS];
	logic                   m_tvalid_q;

	logic     adv;
	logic     emit;
	base_t    base_in;
	ccc_win_t win_a;
	ccc_win_t win_b;
	ccc_inc_t inc_a;
	ccc_inc_t inc_b;
	logic [N_COUNTERS-1:0][1:0] add_a;
	logic [N_COUNTERS-1:0][1:0] add_b;
	logic [N_COUNTERS-1:0]      cnt_nz;

	// Stage advances unless a final base finds the result register occupied and not being taken.
	assign adv      = valid_s1 && (!last_s1 || !m_tvalid_q || m_tready);
	assign emit     = adv && last_s1;
	assign s_tready = !valid_s1 || adv;

	assign base_in = (s_tdata[2:0] > BASE_OTHER) ? BASE_OTHER : s_tdata[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			base_s1  <= base_in;
			zone_s1  <= s_tdata[3];
			zone2_s1 <= s_tdata[4];
			last_s1  <= s_tlast;
		end
	end

	// Pending centre, with the new base as its right neighbour.
	assign win_a = '{prev: prev_q, centre: centre_q, next: base_s1,
		zone: zone_q, second_zone: zone2_q, enable: valid_s1};
	// Final base as centre, with nothing to its right.
	assign win_b = '{prev: centre_q, centre: base_s1, next: BASE_OTHER,
		zone: zone_s1, second_zone: zone2_s1, enable: last_s1};

	ccc_eval u_eval_a (.win(win_a), .inc(inc_a));
	ccc_eval u_eval_b (.win(win_b), .inc(inc_b));

	assign add_a = inc_a;
	assign add_b = inc_b;

	// Window shift; a final base leaves an empty window behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= BASE_OTHER;
			centre_q <= BASE_OTHER;
			zone_q   <= 1'b0;
			zone2_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				prev_q   <= BASE_OTHER;
				centre_q <= BASE_OTHER;
				zone_q   <= 1'b0;
				zone2_q  <= 1'b0;
			end else begin
				prev_q   <= centre_q;
				centre_q <= base_s1;
				zone_q   <= zone_s1;
				zone2_q  <= zone2_s1;
			end
		end
	end

	// Saturating counters and the capped result register.
	for (genvar i = 0; i < N_COUNTERS; i++) begin : g_cnt
		logic [2:0]             tot;
		logic [COUNT_WIDTH:0]   wide;
		logic [COUNT_WIDTH-1:0] sat;
		logic [OUT_WIDTH-1:0]   cap;

		assign tot  = {1'b0, add_a[i]} + {1'b0, add_b[i]};
		assign wide = {1'b0, cnt_q[i]} + (COUNT_WIDTH+1)'(tot);
		assign sat  = wide[COUNT_WIDTH] ? '1 : wide[COUNT_WIDTH-1:0];

		if (COUNT_WIDTH > OUT_WIDTH) begin : g_capped
			assign cap = (|sat[COUNT_WIDTH-1:OUT_WIDTH]) ? '1 : sat[OUT_WIDTH-1:0];
		end else begin : g_plain
			assign cap = OUT_WIDTH'(sat);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (adv) begin
				cnt_q[i] <= last_s1 ? '0 : sat;
			end
		end

		always_ff @(posedge clk) begin
			if (emit) begin
				res_q[i] <= cap;
			end
		end

		assign m_tdata[i*OUT_WIDTH +: OUT_WIDTH] = res_q[i];
		assign cnt_nz[i] = |cnt_q[i];
	end

	// Result valid holds until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	// Checks on the flush and stall logic.
	`CCC_ASSERT_NXT(a_emit_valid, clk, arst_n, emit, m_tvalid, "result not raised after final base")
	`CCC_ASSERT_NXT(a_emit_clear, clk, arst_n, emit, cnt_nz == '0, "counters not cleared after result")
	`CCC_ASSERT_NXT(a_emit_window, clk, arst_n, emit, centre_q == BASE_OTHER && prev_q == BASE_OTHER, "window not emptied after result")
	`CCC_ASSERT_IMP(a_stall_cause, clk, arst_n, !s_tready, valid_s1 && last_s1 && m_tvalid && !m_tready, "input stalled without a held result")

endmodule

// ===== tb/cytosine_context_counter_top_tb.sv =====
module cytosine_context_counter_top_tb;
	import ccc_pkg::*;

	// Base codes that the package leaves unnamed.
	localparam base_t BASE_A = 3'd2;
	localparam base_t BASE_T = 3'd3;

	// Position of each context within a counter set, and the offset of the out set.
	localparam int NEXT_C  = 0;
	localparam int PREV_C  = 1;
	localparam int NEXT_T  = 2;
	localparam int PREV_T  = 3;
	localparam int OUT_SET = 4;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int mismatch_count = 0;

	// Totals still owed by the block, oldest first.
	logic [255:0] expected_totals [$];
	logic [255:0] oldest_totals;

	// Shadow copy of the window and the half-count totals.
	base_t       win_prev;
	base_t       win_centre;
	logic        win_zone;
	logic        win_zone2;
	logic [1:0]  win_fill;
	logic [31:0] half_count [0:7];

	cytosine_context_counter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	function automatic void clear_context_state();
		win_prev = BASE_OTHER;
		win_centre = BASE_OTHER;
		win_zone = 1'b0;
		win_zone2 = 1'b0;
		win_fill = 2'd0;
		for (int k = 0; k < 8; k++)
			half_count[k] = 32'd0;
	endfunction

	// Saturating addition of half-counts to one counter.
	function automatic void bump_count(int idx, int amount);
		logic [32:0] sum;
		sum = {1'b0, half_count[idx]} + 33'(amount);
		half_count[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// How a neighbour relates to the centre: 1 for the C-like partner (C beside a C,
	// G beside a G), 2 for the T-like partner (T beside a C, A beside a G), else 0.
	// Both context tables reduce to rule = 3 * grade(previous) + grade(next).
	function automatic logic [1:0] neighbour_grade(base_t centre, base_t nb);
		if (centre == BASE_C)
			return (nb == BASE_C) ? 2'd1 : (nb == BASE_T) ? 2'd2 : 2'd0;
		return (nb == BASE_G) ? 2'd1 : (nb == BASE_A) ? 2'd2 : 2'd0;
	endfunction

	// Score the centre of the window against the given following base.
	function automatic void fold_centre(base_t nxt);
		logic [1:0] prev_grade;
		logic [1:0] next_grade;
		int weight;
		int set;
		if (win_fill == 2'd0)
			return;
		if (win_centre != BASE_C && win_centre != BASE_G)
			return;
		// Second zone alone is excluded from every count.
		if (!win_zone && win_zone2)
			return;
		prev_grade = neighbour_grade(win_centre, win_prev);
		next_grade = neighbour_grade(win_centre, nxt);
		// One side alone takes a full count, two sides share it.
		weight = (prev_grade != 2'd0 && next_grade != 2'd0) ? 1 : 2;
		set = win_zone ? 0 : OUT_SET;
		if (prev_grade == 2'd1)
			bump_count(set + PREV_C, weight);
		if (prev_grade == 2'd2)
			bump_count(set + PREV_T, weight);
		if (next_grade == 2'd1)
			bump_count(set + NEXT_C, weight);
		if (next_grade == 2'd2)
			bump_count(set + NEXT_T, weight);
	endfunction

	// Advance the shadow window by one accepted base.
	function automatic void account_base(base_t code, logic zone, logic zone2, logic last);
		base_t b;
		logic [255:0] totals;
		b = (code > BASE_OTHER) ? BASE_OTHER : code;
		fold_centre(b);
		win_prev = (win_fill != 2'd0) ? win_centre : BASE_OTHER;
		win_centre = b;
		win_zone = zone;
		win_zone2 = zone2;
		if (win_fill < 2'd2)
			win_fill = win_fill + 2'd1;
		if (last) begin
			// The sequence ends: the final base sees other after it.
			fold_centre(BASE_OTHER);
			for (int k = 0; k < 8; k++)
				totals[32*k +: 32] = half_count[k];
			expected_totals.push_back(totals);
			clear_context_state();
		end
	endfunction

	function automatic string total_label(int k);
		case (k)
			0: return "in_next_c";
			1: return "in_prev_c";
			2: return "in_next_t";
			3: return "in_prev_t";
			4: return "out_next_c";
			5: return "out_prev_c";
			6: return "out_next_t";
			default: return "out_prev_t";
		endcase
	endfunction

	// Compare each result request with the oldest owed totals.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_totals.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				oldest_totals = expected_totals.pop_front();
				for (int k = 0; k < 8; k++) begin
					if (m_tdata[32*k +: 32] !== oldest_totals[32*k +: 32]) begin
						$display("%0t: %s expected %0d, got %0d", $time, total_label(k),
							oldest_totals[32*k +: 32], m_tdata[32*k +: 32]);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Offer one base, with random gaps, and wait until it is accepted.
	// Called and left on a falling edge.
	task automatic send_base(base_t code, logic zone, logic zone2, logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, zone2, zone, code};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		account_base(code, zone, zone2, last);
		@(negedge clk);
	endtask

	// Send a whole sequence written as letters; digits give the spare codes.
	task automatic send_text(string seq, logic zone, logic zone2);
		base_t code;
		for (int i = 0; i < seq.len(); i++) begin
			case (seq[i])
				"C": code = BASE_C;
				"G": code = BASE_G;
				"A": code = BASE_A;
				"T": code = BASE_T;
				"5", "6", "7": code = base_t'(seq[i] - "0");
				default: code = BASE_OTHER;
			endcase
			send_base(code, zone, zone2, i == seq.len() - 1);
		end
	endtask

	// Hold the sender off until every owed result has been taken.
	task automatic hold_until_totals_drained();
		if (expected_totals.size() != 0) begin
			s_tvalid <= 1'b0;
			while (expected_totals.size() != 0)
				@(negedge clk);
		end
	endtask

	// Sequences of one base, evaluated with other on both sides.
	task automatic test_lone_bases();
		send_text("C", 1'b1, 1'b0);
		send_text("G", 1'b0, 1'b0);
		send_text("6", 1'b1, 1'b1);
	endtask

	// C context rules other than C on both sides, in zone and out, with one spare base code.
	task automatic test_context_rules();
		send_text("ACTCCGTCTCAT", 1'b1, 1'b0);
		send_text("ACCT5", 1'b0, 1'b0);
		hold_until_totals_drained();
	endtask

	// Second zone alone is dropped; both flags count in zone.
	task automatic test_zone_selection();
		send_text("CCC7", 1'b0, 1'b1);
		send_text("CGC", 1'b1, 1'b1);
	endtask

	// Random sequences, mostly of real bases, with slowly changing zone flags.
	task automatic test_random_sequences(int n_items, int idle_send, int idle_recv);
		int sent;
		int seq_count;
		int seq_len;
		logic zone;
		logic zone2;
		base_t code;
		sender_idle_pct = idle_send;
		receiver_idle_pct = idle_recv;
		sent = 0;
		seq_count = 0;
		while (sent < n_items) begin
			seq_len = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
			zone = $urandom_range(1);
			zone2 = $urandom_range(1);
			for (int i = 0; i < seq_len; i++) begin
				if ($urandom_range(7) == 0)
					zone = ~zone;
				if ($urandom_range(7) == 0)
					zone2 = ~zone2;
				if ($urandom_range(9) < 8)
					code = base_t'($urandom_range(3));
				else
					code = base_t'($urandom_range(7, 4));
				send_base(code, zone, zone2, i == seq_len - 1);
			end
			sent += seq_len;
			seq_count++;
			if (seq_count == 4)
				hold_until_totals_drained();
		end
	endtask

	initial begin
		clear_context_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_pct = 26;
		receiver_idle_pct = 48;
		test_lone_bases();
		test_context_rules();
		test_zone_selection();
		test_random_sequences(400, 26, 48);
		test_random_sequences(400, 48, 26);
		test_random_sequences(400, 0, 0);

		// Let the last totals come out, then keep watching for strays.
		s_tvalid <= 1'b0;
		while (expected_totals.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("cytosine_context_counter_top_tb: PASS");
		else
			$display("cytosine_context_counter_top_tb: FAIL");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#1000000;
		$display("cytosine_context_counter_top_tb: FAIL");
		$finish;
	end

endmodule
